/* design/rol_pkg.sv */
`default_nettype none

package rol_pkg;

  localparam logic [2:0] OP_PROG_START = 3'd0;
  localparam logic [2:0] OP_SECT_START = 3'd1;
  localparam logic [2:0] OP_SECT_END   = 3'd2;
  localparam logic [2:0] OP_SET_REF    = 3'd3;
  localparam logic [2:0] OP_TEXT_BYTE  = 3'd4;
  localparam logic [2:0] OP_MODIFY     = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;

  localparam logic [1:0] SIGN_KEEP = 2'd0;
  localparam logic [1:0] SIGN_ADD  = 2'd1;
  localparam logic [1:0] SIGN_SUB  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd1;
  localparam logic [1:0] STATUS_BAD_REF = 2'd2;

  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } byte_req_t;

  typedef struct packed {
    logic        clear;
    logic        en;
    logic        we;
    logic [23:0] wdata;
  } ref_req_t;

endpackage

`default_nettype wire

/* design/rol_byte_mem.sv */
`default_nettype none

module rol_byte_mem #(
  parameter int MEM_BYTES = 1048576
) (
  input  wire                          clk,
  input  wire rol_pkg::byte_req_t      req,
  input  wire [$clog2(MEM_BYTES)-1:0]  addr,
  output logic [7:0]                   rdata
);
  import rol_pkg::*;

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[addr] <= req.wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* design/rol_ref_mem.sv */
`default_nettype none

module rol_ref_mem #(
  parameter int REF_ENTRIES = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire rol_pkg::ref_req_t         req,
  input  wire [$clog2(REF_ENTRIES)-1:0]  addr,
  output logic [23:0]                    rdata
);
  import rol_pkg::*;

  logic [23:0]            mem [REF_ENTRIES];
  logic [REF_ENTRIES-1:0] valid;
  logic [23:0]            rd_word;
  logic                   rd_valid;

  // Entries that have not been set since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.en) begin
      if (req.we) begin
        valid[addr] <= 1'b1;
      end else begin
        rd_valid <= valid[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[addr] <= req.wdata;
      end else begin
        rd_word <= mem[addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : 24'd0;

endmodule

`default_nettype wire

/* design/relocating_object_loader.sv */
`default_nettype none
// m_axis_tvalid is registered in S_DONE once the output is free. Control, set-reference
// and text-byte items use S_EXEC and S_DONE; a valid read adds S_RD, a valid modify S_M1 to S_W2.
// A new item is taken only in S_IDLE, after the previous result is registered; the modify
// sequence is set by the single port of the byte memory (three reads, three writes).
// Reset clears the section base, the load origin and the reference table valid bits;
// the byte memory is not initialised and needs no clearing pass.
module relocating_object_loader #(
  parameter int MEM_BYTES   = 1048576,
  parameter int REF_ENTRIES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wen,
  input  wire  [19:0] cfg_wdata,        // load_origin
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // offset[23:0], data_byte[31:24], ref_index[39:32], ref_address[63:40],
  // mod_sign[65:64], section_length[89:66]
  input  wire  [95:0] s_axis_tdata,
  input  wire  [2:0]  s_axis_tuser,     // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[1:0], read_byte[9:2], patched_value[33:10]
  output logic [39:0] m_axis_tdata
);
  import rol_pkg::*;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int REF_AW = $clog2(REF_ENTRIES);
  localparam logic [25:0] MEM_LIMIT = 26'(MEM_BYTES);
  localparam logic [8:0]  REF_LIMIT = 9'(REF_ENTRIES);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_RD   = 9'b000000100,
    S_M1   = 9'b000001000,
    S_M2   = 9'b000010000,
    S_M3   = 9'b000100000,
    S_W1   = 9'b001000000,
    S_W2   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [19:0] origin;
  logic [23:0] base;

  logic [2:0]  it_op;
  logic [23:0] it_offset;
  logic [7:0]  it_data_byte;
  logic [7:0]  it_ref_index;
  logic [23:0] it_ref_address;
  logic [1:0]  it_mod_sign;
  logic [23:0] it_section_length;

  logic [MEM_AW-1:0] mod_addr;
  logic [7:0]  b0, b1;
  logic [23:0] patch_v;
  logic [1:0]  res_status;
  logic [7:0]  res_byte;
  logic [23:0] res_patch;

  byte_req_t         mem_req;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_rdata;
  ref_req_t          ref_req;
  logic [23:0]       ref_rdata;

  logic [24:0] sum_addr;
  logic [25:0] mod_end;
  logic        addr_oob, mod_oob, read_oob, idx_oob, uses_ref;
  logic [23:0] field_v, new_v;
  logic        out_free;
  logic [1:0]  exec_status;

  rol_byte_mem #(.MEM_BYTES(MEM_BYTES)) u_byte_mem (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  rol_ref_mem #(.REF_ENTRIES(REF_ENTRIES)) u_ref_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (ref_req),
    .addr  (it_ref_index[REF_AW-1:0]),
    .rdata (ref_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign sum_addr = {1'b0, base} + {1'b0, it_offset};
  assign mod_end  = {1'b0, sum_addr} + 26'd2;
  assign addr_oob = {1'b0, sum_addr} >= MEM_LIMIT;
  assign mod_oob  = mod_end >= MEM_LIMIT;
  assign read_oob = {2'b00, it_offset} >= MEM_LIMIT;
  assign idx_oob  = {1'b0, it_ref_index} >= REF_LIMIT;
  assign uses_ref = (it_mod_sign == SIGN_ADD) || (it_mod_sign == SIGN_SUB);

  assign field_v = {b0, b1, mem_rdata};

  always_comb begin
    case (it_mod_sign)
      SIGN_ADD: new_v = field_v + ref_rdata;
      SIGN_SUB: new_v = field_v - ref_rdata;
      default:  new_v = field_v;
    endcase
  end

  always_comb begin
    exec_status = STATUS_OK;
    case (it_op)
      OP_SET_REF:   if (idx_oob) exec_status = STATUS_BAD_REF;
      OP_TEXT_BYTE: if (addr_oob) exec_status = STATUS_BAD_ADDR;
      OP_MODIFY: begin
        if (mod_oob) begin
          exec_status = STATUS_BAD_ADDR;
        end else if (uses_ref && idx_oob) begin
          exec_status = STATUS_BAD_REF;
        end
      end
      OP_READ:      if (read_oob) exec_status = STATUS_BAD_ADDR;
      default:      exec_status = STATUS_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    mem_req    = '0;
    mem_addr   = '0;
    ref_req    = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (it_op) inside
          OP_PROG_START, OP_SECT_START: ref_req.clear = 1'b1;
          OP_SET_REF: begin
            if (!idx_oob) begin
              ref_req.en    = 1'b1;
              ref_req.we    = 1'b1;
              ref_req.wdata = it_ref_address;
            end
          end
          OP_TEXT_BYTE: begin
            if (!addr_oob) begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.wdata = it_data_byte;
              mem_addr      = sum_addr[MEM_AW-1:0];
            end
          end
          OP_MODIFY: begin
            if (exec_status == STATUS_OK) begin
              mem_req.en = 1'b1;
              mem_addr   = sum_addr[MEM_AW-1:0];
              ref_req.en = uses_ref;
              state_next = S_M1;
            end
          end
          OP_READ: begin
            if (!read_oob) begin
              mem_req.en = 1'b1;
              mem_addr   = it_offset[MEM_AW-1:0];
              state_next = S_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RD: state_next = S_DONE;
      S_M1: begin
        mem_req.en = 1'b1;
        mem_addr   = mod_addr + MEM_AW'(1);
        state_next = S_M2;
      end
      S_M2: begin
        mem_req.en = 1'b1;
        mem_addr   = mod_addr + MEM_AW'(2);
        state_next = S_M3;
      end
      S_M3: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = new_v[23:16];
        mem_addr      = mod_addr;
        state_next    = S_W1;
      end
      S_W1: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = patch_v[15:8];
        mem_addr      = mod_addr + MEM_AW'(1);
        state_next    = S_W2;
      end
      S_W2: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = patch_v[7:0];
        mem_addr      = mod_addr + MEM_AW'(2);
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      origin        <= 20'd0;
      base          <= 24'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        origin <= cfg_wdata;
      end
      if (state == S_EXEC) begin
        if (it_op == OP_PROG_START) begin
          base <= {4'd0, origin};
        end else if (it_op == OP_SECT_END) begin
          base <= base + it_section_length;
        end
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      it_op             <= s_axis_tuser;
      it_offset         <= s_axis_tdata[23:0];
      it_data_byte      <= s_axis_tdata[31:24];
      it_ref_index      <= s_axis_tdata[39:32];
      it_ref_address    <= s_axis_tdata[63:40];
      it_mod_sign       <= s_axis_tdata[65:64];
      it_section_length <= s_axis_tdata[89:66];
    end
    if (state == S_EXEC) begin
      res_status <= exec_status;
      res_byte   <= 8'd0;
      res_patch  <= 24'd0;
      mod_addr   <= sum_addr[MEM_AW-1:0];
    end
    if (state == S_RD) begin
      res_byte <= mem_rdata;
    end
    if (state == S_M1) begin
      b0 <= mem_rdata;
    end
    if (state == S_M2) begin
      b1 <= mem_rdata;
    end
    if (state == S_M3) begin
      patch_v   <= new_v;
      res_patch <= new_v;
    end
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {6'd0, res_patch, res_byte, res_status};
    end
  end

endmodule

`default_nettype wire

/* tb/tb_relocating_object_loader.sv */
`timescale 1ns / 1ps

module tb_relocating_object_loader;
  import rol_pkg::*;

  localparam int MEM_BYTES      = 1048576;
  localparam int REF_ENTRIES    = 16;
  localparam int ITEM_COUNT     = 1650;
  localparam int PHASES         = 7;
  localparam int SETTLE_CYCLES  = 12;
  localparam int QUIET_LIMIT    = 2000;
  localparam logic [19:0] DIRECTED_ORIGIN = 20'h00100;
  localparam logic [2:0]  OP_UNUSED  = 3'd7;
  localparam logic [1:0]  SIGN_SPARE = 2'd3;

  typedef struct {
    logic [2:0]  op;
    logic [23:0] offset;
    logic [7:0]  data_byte;
    logic [7:0]  ref_index;
    logic [23:0] ref_address;
    logic [1:0]  mod_sign;
    logic [23:0] section_length;
  } load_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [23:0] patched_value;
  } load_outcome_t;

  class loader_scoreboard;
    logic [7:0]    image [MEM_BYTES];
    bit            image_written [MEM_BYTES];
    int unsigned   written_addrs [$];
    logic [23:0]   ref_table [REF_ENTRIES];
    logic [23:0]   section_base;
    logic [19:0]   load_origin;
    load_outcome_t expected_outcomes [$];
    int            errors;

    function new();
      foreach (ref_table[i]) ref_table[i] = '0;
      section_base = '0;
      load_origin = '0;
      errors = 0;
    endfunction

    function void store(int unsigned addr, logic [7:0] value);
      if (!image_written[addr]) begin
        image_written[addr] = 1'b1;
        written_addrs.push_back(addr);
      end
      image[addr] = value;
    endfunction

    function bit holds_field(int unsigned addr);
      return addr + 2 < MEM_BYTES && image_written[addr] && image_written[addr + 1]
             && image_written[addr + 2];
    endfunction

    function void note_item(load_item_t it);
      load_outcome_t res;
      int unsigned   addr;
      logic [23:0]   field;
      res = '{STATUS_OK, 8'h00, 24'h000000};
      addr = 32'(section_base) + 32'(it.offset);
      case (it.op)
        OP_PROG_START: begin
          section_base = {4'h0, load_origin};
          foreach (ref_table[i]) ref_table[i] = '0;
        end
        OP_SECT_START: foreach (ref_table[i]) ref_table[i] = '0;
        OP_SECT_END: section_base = section_base + it.section_length;
        OP_SET_REF: begin
          if (it.ref_index >= REF_ENTRIES) res.status = STATUS_BAD_REF;
          else ref_table[it.ref_index] = it.ref_address;
        end
        OP_TEXT_BYTE: begin
          if (addr >= MEM_BYTES) res.status = STATUS_BAD_ADDR;
          else store(addr, it.data_byte);
        end
        OP_MODIFY: begin
          if (addr + 2 >= MEM_BYTES) begin
            res.status = STATUS_BAD_ADDR;
          end else if ((it.mod_sign == SIGN_ADD || it.mod_sign == SIGN_SUB)
                       && it.ref_index >= REF_ENTRIES) begin
            res.status = STATUS_BAD_REF;
          end else begin
            field = {image[addr], image[addr + 1], image[addr + 2]};
            if (it.mod_sign == SIGN_ADD) field = field + ref_table[it.ref_index];
            else if (it.mod_sign == SIGN_SUB) field = field - ref_table[it.ref_index];
            store(addr, field[23:16]);
            store(addr + 1, field[15:8]);
            store(addr + 2, field[7:0]);
            res.patched_value = field;
          end
        end
        OP_READ: begin
          if (it.offset >= MEM_BYTES) res.status = STATUS_BAD_ADDR;
          else res.read_byte = image[it.offset];
        end
        default: ;
      endcase
      expected_outcomes.push_back(res);
    endfunction

    function void check_result(logic [39:0] word);
      load_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result transaction %h arrived with nothing outstanding", word);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (word[1:0] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, word[1:0]);
        errors++;
      end
      if (word[9:2] !== want.read_byte) begin
        $error("read_byte: expected %h, got %h", want.read_byte, word[9:2]);
        errors++;
      end
      if (word[33:10] !== want.patched_value) begin
        $error("patched_value: expected %h, got %h", want.patched_value, word[33:10]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  loader_scoreboard sb = new();
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;
  int items_sent = 0;

  relocating_object_loader #(
    .MEM_BYTES  (MEM_BYTES),
    .REF_ENTRIES(REF_ENTRIES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic load_item_t fresh_item(logic [2:0] op);
    load_item_t it;
    it.op = op;
    it.offset = 24'($urandom);
    it.data_byte = 8'($urandom);
    it.ref_index = 8'($urandom);
    it.ref_address = 24'($urandom);
    it.mod_sign = 2'($urandom);
    it.section_length = 24'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(REF_ENTRIES, 255));
    return 8'($urandom_range(0, REF_ENTRIES - 1));
  endfunction

  function automatic logic [23:0] next_length();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 'h3FF) - sb.section_base);
      default: return 24'($urandom_range(0, 'h800));
    endcase
  endfunction

  task automatic send_item(load_item_t it);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {6'h00, it.section_length, it.mod_sign, it.ref_address, it.ref_index,
                      it.data_byte, it.offset};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // Fields that the operation does not use keep random contents.
  task automatic issue(logic [2:0] op, logic [23:0] offset = '0, logic [23:0] value = '0,
                       logic [7:0] index = '0, logic [1:0] sign = SIGN_KEEP);
    load_item_t it;
    it = fresh_item(op);
    case (op)
      OP_SECT_END: it.section_length = value;
      OP_SET_REF: begin
        it.ref_index = index;
        it.ref_address = value;
      end
      OP_TEXT_BYTE: begin
        it.offset = offset;
        it.data_byte = value[7:0];
      end
      OP_MODIFY: begin
        it.offset = offset;
        it.ref_index = index;
        it.mod_sign = sign;
      end
      OP_READ: it.offset = offset;
      default: ;
    endcase
    send_item(it);
  endtask

  task automatic write_origin(logic [19:0] origin);
    cfg_wen   <= 1'b1;
    cfg_wdata <= origin;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.load_origin = origin;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_back();
    if (sb.written_addrs.size() == 0 || $urandom_range(0, 7) == 0)
      issue(OP_READ, 24'($urandom_range(MEM_BYTES, 24'hFFFFFF)));
    else
      issue(OP_READ, 24'(sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)]));
  endtask

  // Relocates a field loaded by an earlier item, as a loader does for external references.
  task automatic patch_earlier();
    int unsigned target;
    if (sb.written_addrs.size() == 0) return;
    target = sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
    if (sb.holds_field(target) && target >= sb.section_base)
      issue(OP_MODIFY, 24'(target - sb.section_base), 0, pick_index(),
            2'($urandom_range(0, 3)));
  endtask

  task automatic load_section();
    int start;
    int len;
    if ($urandom_range(0, 5) == 0) issue(OP_PROG_START);
    else issue(OP_SECT_START);
    repeat ($urandom_range(1, 4))
      issue(OP_SET_REF, 0, 24'($urandom), 8'($urandom_range(0, REF_ENTRIES - 1)));
    repeat ($urandom_range(1, 4)) begin
      start = $urandom_range(0, 'h3FF);
      len = $urandom_range(3, 8);
      for (int i = 0; i < len; i++) issue(OP_TEXT_BYTE, 24'(start + i), 24'($urandom));
      repeat ($urandom_range(0, 2))
        issue(OP_MODIFY, 24'(start + $urandom_range(0, len - 3)), 0, pick_index(),
              2'($urandom_range(0, 3)));
      repeat ($urandom_range(0, 2)) read_back();
    end
    if ($urandom_range(0, 2) == 0) patch_earlier();
    issue(OP_SECT_END, 0, next_length());
  endtask

  // Unstructured transactions; reads and patches are steered away from bytes never loaded.
  task automatic send_noise();
    load_item_t  it;
    int unsigned addr;
    it = fresh_item(3'($urandom_range(0, 7)));
    addr = 32'(sb.section_base) + 32'(it.offset);
    if (it.op == OP_READ && it.offset < MEM_BYTES && !sb.image_written[it.offset])
      it.offset = 24'hFFFFFF;
    if (it.op == OP_MODIFY && addr + 2 < MEM_BYTES && !sb.holds_field(addr))
      it.offset = 24'hFFFFFF;
    send_item(it);
  endtask

  task automatic run_phase(int target);
    issue(OP_PROG_START);
    while (items_sent < target) begin
      source_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else load_section();
    end
  endtask

  task automatic directed_items();
    issue(OP_READ, 24'hFFFFFF);
    issue(OP_UNUSED);
    issue(OP_PROG_START);
    issue(OP_SET_REF, 0, 24'hFFFFFF, 0);
    issue(OP_SET_REF, 0, 24'h000001, 8'(REF_ENTRIES - 1));
    issue(OP_SET_REF, 0, 24'h123456, 8'(REF_ENTRIES));
    issue(OP_SET_REF, 0, 24'h654321, 8'hFF);
    issue(OP_TEXT_BYTE, 0, 24'hFF);
    issue(OP_TEXT_BYTE, 1, 24'hFF);
    issue(OP_TEXT_BYTE, 2, 24'hFE);
    issue(OP_TEXT_BYTE, 3, 24'h00);
    issue(OP_MODIFY, 0, 0, 8'(REF_ENTRIES - 1), SIGN_ADD);
    issue(OP_MODIFY, 0, 0, 8'(REF_ENTRIES - 1), SIGN_ADD);
    issue(OP_MODIFY, 1, 0, 0, SIGN_SUB);
    issue(OP_MODIFY, 0, 0, 8'hC8, SIGN_SPARE);
    issue(OP_MODIFY, 0, 0, 8'(REF_ENTRIES), SIGN_SUB);
    issue(OP_MODIFY, 0, 0, 8'hFF, SIGN_KEEP);
    // The field would run past the top of memory and the index is also bad.
    issue(OP_MODIFY, 24'(MEM_BYTES - 2 - DIRECTED_ORIGIN), 0, 8'h63, SIGN_ADD);
    issue(OP_TEXT_BYTE, 24'(MEM_BYTES - 1 - DIRECTED_ORIGIN), 24'h5A);
    issue(OP_TEXT_BYTE, 24'hFFFFFF, 24'h01);
    issue(OP_READ, 24'(MEM_BYTES - 1));
    issue(OP_READ, 24'(MEM_BYTES));
    issue(OP_SECT_END, 0, 24'hFFFFFF);
    issue(OP_SECT_START);
    issue(OP_MODIFY, 1, 0, 8'(REF_ENTRIES - 1), SIGN_ADD);
  endtask

  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_relocating_object_loader: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [19:0] origins [PHASES];
    origins = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFC00, 20'h00000, 20'h00001, 20'h00000};
    origins[2] = 20'($urandom);
    origins[4] = 20'($urandom_range(0, 'h7FFFF));
    origins[6] = 20'($urandom_range(0, 'hFFFF));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_origin(DIRECTED_ORIGIN);
    directed_items();
    foreach (origins[p]) begin
      settle();
      write_origin(origins[p]);
      run_phase(ITEM_COUNT * (p + 1) / PHASES);
    end
    settle();
    if (sb.errors == 0 && sb.expected_outcomes.size() == 0)
      $display("tb_relocating_object_loader: PASS");
    else
      $display("tb_relocating_object_loader: FAIL");
    $finish;
  end

endmodule
